### rtl/mvt_pkg.sv
// Shared types and constants for the 4x4 matrix-vector transform.
// Used by mvt_dot4, mat4_vector_transform_top and mvt_checker; depends on nothing.
package mvt_pkg;

  // Component width of vectors and results (signed Q8.8).
  localparam int DATA_WIDTH     = 16;
  // Coefficient lane width (signed Q4.12) and row layout.
  localparam int COEF_W         = 16;
  localparam int NUM_ROWS       = 4;
  localparam int NUM_COLS       = 4;
  localparam int ROW_W          = COEF_W * NUM_COLS;
  // Default fraction bits of a coefficient.
  localparam int COEF_FRAC_BITS = 12;
  // Width of the configuration index; indexes past the last row are ignored.
  localparam int CFG_IDX_W      = 4;

  // Saturation limits of a result component.
  localparam logic signed [DATA_WIDTH-1:0] RES_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] RES_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0 = CFG_IDX_W'(0),
    REG_ROW1 = CFG_IDX_W'(1),
    REG_ROW2 = CFG_IDX_W'(2),
    REG_ROW3 = CFG_IDX_W'(3)
  } reg_idx_t;

  // Identity matrix after reset: one (Q4.12) on the diagonal of each row.
  localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

  // Input request: one column vector.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] in_x;
    logic signed [DATA_WIDTH-1:0] in_y;
    logic signed [DATA_WIDTH-1:0] in_z;
    logic signed [DATA_WIDTH-1:0] in_w;
  } in_t;

  // Output request: the four dot products and the clip flag.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;
    logic signed [DATA_WIDTH-1:0] out_w;
    logic                         saturated;
  } out_t;

  // Load enables of the four pipeline stages.
  typedef struct packed {
    logic mul;
    logic pair;
    logic total;
    logic clip;
  } stage_en_t;

endpackage

### rtl/mvt_dot4.sv
// One row's dot product: four-stage pipeline of multiply, pair add, round, clip.
// Depends on mvt_pkg for the vector type, widths and stage enables.
module mvt_dot4 import mvt_pkg::*; #(
  parameter int FRAC_BITS = COEF_FRAC_BITS
) (
  input  logic                         clk,
  input  stage_en_t                    en,
  input  in_t                          vec,
  input  logic [ROW_W-1:0]             coefs,
  output logic signed [DATA_WIDTH-1:0] result,
  output logic                         clipped
);

  localparam int PROD_W = DATA_WIDTH + COEF_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 3;
  // Half an output LSB; zero when there are no fraction bits.
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = (SUM_W'(1) << FRAC_BITS) >> 1;

  logic signed [DATA_WIDTH-1:0] comp [NUM_COLS];
  logic signed [PROD_W-1:0]     prod [NUM_COLS];
  logic signed [PAIR_W-1:0]     pair_lo;
  logic signed [PAIR_W-1:0]     pair_hi;
  logic signed [SUM_W-1:0]      rounded;
  logic signed [SUM_W-1:0]      total_next;

  assign comp[0] = vec.in_x;
  assign comp[1] = vec.in_y;
  assign comp[2] = vec.in_z;
  assign comp[3] = vec.in_w;

  // Stage 1: four exact products of coefficient lane and component.
  always_ff @(posedge clk) begin
    if (en.mul) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        prod[c] <= PROD_W'($signed(coefs[c*COEF_W +: COEF_W])) * PROD_W'(comp[c]);
      end
    end
  end

  // Stage 2: add the products in pairs.
  always_ff @(posedge clk) begin
    if (en.pair) begin
      pair_lo <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair_hi <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
  end

  // Stage 3: full sum plus rounding bias, then drop the fraction bits (floor).
  assign total_next = SUM_W'(pair_lo) + SUM_W'(pair_hi) + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (en.total) begin
      rounded <= total_next >>> FRAC_BITS;
    end
  end

  // Stage 4: clamp to the signed result range and note any clipping.
  always_ff @(posedge clk) begin
    if (en.clip) begin
      if (rounded > SUM_W'(RES_MAX)) begin
        result  <= RES_MAX;
        clipped <= 1'b1;
      end else if (rounded < SUM_W'(RES_MIN)) begin
        result  <= RES_MIN;
        clipped <= 1'b1;
      end else begin
        result  <= rounded[DATA_WIDTH-1:0];
        clipped <= 1'b0;
      end
    end
  end

endmodule

### rtl/mat4_vector_transform_top.sv
// Top level of the 4x4 matrix-vector transform: matrix registers, pipeline control.
// Depends on mvt_pkg and instantiates one mvt_dot4 per matrix row.
//
//   channel | signals                               | direction | accepted when
//   --------+---------------------------------------+-----------+-------------------------
//   input   | in_valid, in_stall, in_data           | in        | in_valid && !in_stall
//   output  | out_valid, out_stall, out_data        | out       | out_valid && !out_stall
//   config  | cfg_valid, cfg_ready, cfg_index/_data | in        | cfg_valid && cfg_ready
//
// One vector is accepted per cycle while in_stall is low; its result is offered from the
// last of four register stages (multiply, pair add, round, clip).
// A stalled output holds; upstream stages still advance into empty slots.
// Reset empties the pipeline and loads the identity matrix.
// Matrix rows must be written only while the pipeline is empty; the block does not enforce it.
module mat4_vector_transform_top import mvt_pkg::*; #(
  parameter int FRAC_BITS = COEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data
);

  logic [ROW_W-1:0]             matrix_row [NUM_ROWS];
  logic                         mul_valid;
  logic                         pair_valid;
  logic                         total_valid;
  stage_en_t                    en;
  logic signed [DATA_WIDTH-1:0] result  [NUM_ROWS];
  logic                         clipped [NUM_ROWS];

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_row[0] <= ROW0_RESET;
      matrix_row[1] <= ROW1_RESET;
      matrix_row[2] <= ROW2_RESET;
      matrix_row[3] <= ROW3_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW0: matrix_row[0] <= cfg_data;
        REG_ROW1: matrix_row[1] <= cfg_data;
        REG_ROW2: matrix_row[2] <= cfg_data;
        REG_ROW3: matrix_row[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on.
  assign en.clip  = !out_valid || !out_stall;
  assign en.total = !total_valid || en.clip;
  assign en.pair  = !pair_valid || en.total;
  assign en.mul   = !mul_valid || en.pair;
  assign in_stall = !en.mul;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid   <= 1'b0;
      pair_valid  <= 1'b0;
      total_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (en.mul) begin
        mul_valid <= in_valid;
      end
      if (en.pair) begin
        pair_valid <= mul_valid;
      end
      if (en.total) begin
        total_valid <= pair_valid;
      end
      if (en.clip) begin
        out_valid <= total_valid;
      end
    end
  end

  // One dot product pipeline per matrix row.
  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    mvt_dot4 #(
      .FRAC_BITS(FRAC_BITS)
    ) u_dot (
      .clk    (clk),
      .en     (en),
      .vec    (in_data),
      .coefs  (matrix_row[r]),
      .result (result[r]),
      .clipped(clipped[r])
    );
  end

  // Result request from the clip stage registers.
  assign out_data.out_x     = result[0];
  assign out_data.out_y     = result[1];
  assign out_data.out_z     = result[2];
  assign out_data.out_w     = result[3];
  assign out_data.saturated = clipped[0] | clipped[1] | clipped[2] | clipped[3];

endmodule

### rtl/mvt_checker.sv
// Port-level checks for the matrix-vector transform, bound to the top level.
// Depends on mvt_pkg and mat4_vector_transform_top.
module mvt_checker import mvt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // Input back-pressure only comes from a full pipe ending in a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A clip flag means at least one component sits at a limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.out_x == RES_MAX || out_data.out_x == RES_MIN ||
       out_data.out_y == RES_MAX || out_data.out_y == RES_MIN ||
       out_data.out_z == RES_MAX || out_data.out_z == RES_MIN ||
       out_data.out_w == RES_MAX || out_data.out_w == RES_MIN))
    else $error("clip flag without a clipped component");

endmodule

bind mat4_vector_transform_top mvt_checker u_mvt_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
